[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the touch pad baseline tracker checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante
`define TPBH_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpbh assertion failed");

// Check that cons holds in the cycle after ante
`define TPBH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpbh assertion failed");

`endif

[rtl/tpbh_pkg.sv]
// ----------------------------------------------------------------------------
// tpbh_pkg
// Widths, constants, register indexes and the controller/datapath interface
// types of the touch pad baseline tracker.
// ----------------------------------------------------------------------------
package tpbh_pkg;

    // Field widths
    localparam int PAD_W      = 4;
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int BASE_W     = SAMPLE_W + FRAC_W;
    localparam int SUM_W      = 24;
    localparam int SEEN_W     = 8;
    localparam int GAIN_W     = 16;
    localparam int PROD_W     = BASE_W + GAIN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Default pad count
    localparam int PADS_DEFAULT = 16;

    // Automatic threshold factors, Q0.16
    localparam logic [GAIN_W-1:0] K_ON  = 16'd9830;
    localparam logic [GAIN_W-1:0] K_OFF = 16'd5243;

    // Calibration sample counter saturates here
    localparam logic [SEEN_W-1:0] SEEN_MAX = 8'd255;

    // Divider step counter
    localparam int DIV_CNT_W = $clog2(SUM_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(SUM_W - 1);

    // Register reset values
    localparam logic [SAMPLE_W-1:0] MAX_CHARGE_RST = 16'd2000;
    localparam logic [SAMPLE_W-1:0] ON_THR_RST     = 16'd0;
    localparam logic [SAMPLE_W-1:0] OFF_THR_RST    = 16'd0;
    localparam logic [GAIN_W-1:0]   GAIN_RST       = 16'd655;
    localparam logic [SEEN_W-1:0]   CALIB_CNT_RST  = 8'd16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHARGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ON_THR     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CALIB_CNT  = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic fetch;
        logic cal_acc;
        logic div_start;
        logic div_step;
        logic cal_write;
        logic mul_on;
        logic mul_off;
        logic decide;
        logic mul_trk;
        logic scan_write;
        logic null_write;
    } tpbh_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pad_ok;
        logic scan;
        logic cal_complete;
        logic div_last;
    } tpbh_stat_t;

endpackage

[rtl/touch_pad_baseline_hysteresis.sv]
// ----------------------------------------------------------------------------
// touch_pad_baseline_hysteresis
// Capacitive touch pad baseline tracker with press hysteresis.
// ----------------------------------------------------------------------------
// One item at a time: an item is taken only while the block is idle, and
// the next one can be taken the cycle after its result is loaded, even if
// that result is still waiting downstream. A scan item makes three passes
// through the shared 32x16 multiplier (on threshold, off threshold,
// tracking step). A calibration item that completes calibration also runs
// the 24-step restoring divider that forms the mean. An item for a pad
// beyond PADS goes straight to its result. A stalled output holds the item
// in its write state. All per-pad state is cleared by reset; the
// configuration port is always ready.
// ----------------------------------------------------------------------------
module touch_pad_baseline_hysteresis #(
    parameter int PADS = tpbh_pkg::PADS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            mode,
    input  logic [tpbh_pkg::PAD_W-1:0]      pad,
    input  logic [tpbh_pkg::SAMPLE_W-1:0]   sample_us,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tpbh_pkg::PAD_W-1:0]      pad_out,
    output logic                            pressed,
    output logic                            rose,
    output logic                            fell,
    output logic [tpbh_pkg::SAMPLE_W-1:0]   clamped_us,
    output logic [tpbh_pkg::SAMPLE_W-1:0]   baseline_us,
    output logic                            calib_done,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tpbh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpbh_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tpbh_pkg::*;

    tpbh_cmd_t  cmd;
    tpbh_stat_t stat;

    assign cfg_ready = 1'b1;

    tpbh_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    tpbh_datapath #(
        .PADS (PADS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mode        (mode),
        .pad         (pad),
        .sample_us   (sample_us),
        .pad_out     (pad_out),
        .pressed     (pressed),
        .rose        (rose),
        .fell        (fell),
        .clamped_us  (clamped_us),
        .baseline_us (baseline_us),
        .calib_done  (calib_done)
    );

endmodule

[rtl/tpbh_datapath.sv]
// ----------------------------------------------------------------------------
// tpbh_datapath
// Per-pad state stores, configuration registers, shared 32x16 multiplier,
// restoring divider for the calibration mean and the result register.
// ----------------------------------------------------------------------------
module tpbh_datapath #(
    parameter int PADS = tpbh_pkg::PADS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tpbh_pkg::tpbh_cmd_t             cmd,
    output tpbh_pkg::tpbh_stat_t            stat,
    input  logic                            cfg_we,
    input  logic [tpbh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpbh_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            mode,
    input  logic [tpbh_pkg::PAD_W-1:0]      pad,
    input  logic [tpbh_pkg::SAMPLE_W-1:0]   sample_us,
    output logic [tpbh_pkg::PAD_W-1:0]      pad_out,
    output logic                            pressed,
    output logic                            rose,
    output logic                            fell,
    output logic [tpbh_pkg::SAMPLE_W-1:0]   clamped_us,
    output logic [tpbh_pkg::SAMPLE_W-1:0]   baseline_us,
    output logic                            calib_done
);
    import tpbh_pkg::*;

    localparam int PIDX_W = (PADS > 1) ? $clog2(PADS) : 1;

    // Configuration registers
    logic [SAMPLE_W-1:0] maxc_reg;
    logic [SAMPLE_W-1:0] on_thr_reg;
    logic [SAMPLE_W-1:0] off_thr_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [SEEN_W-1:0]   ccnt_reg;

    // Per-pad state
    logic [BASE_W-1:0] base_mem [0:PADS-1];
    logic [SUM_W-1:0]  sum_mem  [0:PADS-1];
    logic [SEEN_W-1:0] seen_mem [0:PADS-1];
    logic [PADS-1:0]   press_reg;

    // Item working registers
    logic                mode_reg;
    logic [PAD_W-1:0]    pad_reg;
    logic [SAMPLE_W-1:0] clamped_reg;
    logic                was_reg;
    logic [BASE_W-1:0]   bq_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SEEN_W-1:0]   seen_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [SAMPLE_W-1:0] thr_on_reg;
    logic                on_reg;
    logic                up_reg;
    logic [BASE_W-1:0]   mag_reg;

    // Divider registers
    logic [SUM_W-1:0]     quo_reg;
    logic [SEEN_W-1:0]    rem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;

    // Result register
    logic [PAD_W-1:0]    res_pad_reg;
    logic                res_pressed_reg;
    logic                res_rose_reg;
    logic                res_fell_reg;
    logic [SAMPLE_W-1:0] res_clamped_reg;
    logic [SAMPLE_W-1:0] res_base_reg;
    logic                res_done_reg;

    logic [PIDX_W-1:0]   idx;
    logic                pad_ok;
    logic [SAMPLE_W-1:0] clamp_w;
    logic [SEEN_W-1:0]   need_w;
    logic                complete_w;
    logic [SEEN_W:0]     shifted_w;
    logic                div_ge_w;
    logic [BASE_W-1:0]   mul_a;
    logic [GAIN_W-1:0]   mul_b;
    logic [SAMPLE_W-1:0] base_int_w;
    logic [SAMPLE_W-1:0] delta_w;
    logic [SAMPLE_W-1:0] thr_off_w;
    logic                on_w;
    logic [BASE_W-1:0]   target_w;
    logic                up_w;
    logic [BASE_W-1:0]   bq_new_w;

    assign idx     = pad_reg[PIDX_W-1:0];
    assign pad_ok  = (32'(pad_reg) < PADS);
    assign clamp_w = (sample_us < maxc_reg) ? sample_us : maxc_reg;

    // Calibration completes once the summed count reaches the target
    assign need_w     = (ccnt_reg == '0) ? SEEN_W'(1) : ccnt_reg;
    assign complete_w = (seen_reg >= need_w);

    // One restoring divide step: shift in the next dividend bit and try
    assign shifted_w = {rem_reg, quo_reg[SUM_W-1]};
    assign div_ge_w  = (shifted_w >= {1'b0, seen_reg});

    assign stat.pad_ok       = pad_ok;
    assign stat.scan         = mode_reg;
    assign stat.cal_complete = complete_w;
    assign stat.div_last     = (dcnt_reg == DIV_LAST);

    // Pick the multiplier operands
    always_comb
    begin
        mul_a = bq_reg;
        mul_b = K_ON;
        if (cmd.mul_trk)
        begin
            mul_a = mag_reg;
            mul_b = gain_reg;
        end
        else if (cmd.mul_off)
        begin
            mul_b = K_OFF;
        end
    end

    // Press decision and tracking distance
    assign base_int_w = bq_reg[BASE_W-1:FRAC_W];
    assign delta_w    = (clamped_reg > base_int_w) ? (clamped_reg - base_int_w) : '0;
    assign thr_off_w  = (off_thr_reg != '0) ? off_thr_reg : prod_reg[PROD_W-1:BASE_W];
    assign on_w       = was_reg ? (delta_w >= thr_off_w)
                                : ((delta_w >= thr_on_reg) && (clamped_reg < maxc_reg));
    assign target_w   = {clamped_reg, {FRAC_W{1'b0}}};
    assign up_w       = (target_w >= bq_reg);

    // Move the baseline toward the sample by the scaled step
    assign bq_new_w = up_reg ? (bq_reg + prod_reg[PROD_W-1:FRAC_W])
                             : (bq_reg - prod_reg[PROD_W-1:FRAC_W]);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxc_reg    <= MAX_CHARGE_RST;
            on_thr_reg  <= ON_THR_RST;
            off_thr_reg <= OFF_THR_RST;
            gain_reg    <= GAIN_RST;
            ccnt_reg    <= CALIB_CNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_CHARGE: maxc_reg    <= cfg_data;
                REG_ON_THR:     on_thr_reg  <= cfg_data;
                REG_OFF_THR:    off_thr_reg <= cfg_data;
                REG_TRACK_GAIN: gain_reg    <= cfg_data;
                REG_CALIB_CNT:  ccnt_reg    <= cfg_data[SEEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Per-pad stores: write back at the end of each calibration or scan item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PADS; i++)
            begin
                base_mem[i] <= '0;
                sum_mem[i]  <= '0;
                seen_mem[i] <= '0;
            end
            press_reg <= '0;
        end
        else
        begin
            if (cmd.cal_write)
            begin
                if (complete_w)
                begin
                    base_mem[idx]  <= {quo_reg[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
                    sum_mem[idx]   <= '0;
                    seen_mem[idx]  <= '0;
                    press_reg[idx] <= 1'b0;
                end
                else
                begin
                    sum_mem[idx]  <= sum_reg;
                    seen_mem[idx] <= seen_reg;
                end
            end
            if (cmd.scan_write)
            begin
                press_reg[idx] <= on_reg;
                if (!on_reg)
                begin
                    base_mem[idx] <= bq_new_w;
                end
            end
        end
    end

    // Item working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg    <= mode;
            pad_reg     <= pad;
            clamped_reg <= clamp_w;
        end
        if (cmd.fetch)
        begin
            bq_reg   <= base_mem[idx];
            sum_reg  <= sum_mem[idx];
            seen_reg <= seen_mem[idx];
            was_reg  <= press_reg[idx];
        end
        if (cmd.cal_acc)
        begin
            sum_reg <= sum_reg + SUM_W'(clamped_reg);
            if (seen_reg < SEEN_MAX)
            begin
                seen_reg <= seen_reg + SEEN_W'(1);
            end
        end
        if (cmd.mul_on || cmd.mul_off || cmd.mul_trk)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (cmd.mul_off)
        begin
            thr_on_reg <= (on_thr_reg != '0) ? on_thr_reg : prod_reg[PROD_W-1:BASE_W];
        end
        if (cmd.decide)
        begin
            on_reg  <= on_w;
            up_reg  <= up_w;
            mag_reg <= up_w ? (target_w - bq_reg) : (bq_reg - target_w);
        end
    end

    // Restoring divider for the calibration mean
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg  <= sum_reg;
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= {quo_reg[SUM_W-2:0], div_ge_w};
            rem_reg  <= div_ge_w ? SEEN_W'(shifted_w - {1'b0, seen_reg})
                                 : shifted_w[SEEN_W-1:0];
            dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.cal_write || cmd.scan_write || cmd.null_write)
        begin
            res_pad_reg     <= pad_reg;
            res_clamped_reg <= clamped_reg;
        end
        if (cmd.cal_write)
        begin
            res_pressed_reg <= complete_w ? 1'b0 : was_reg;
            res_rose_reg    <= 1'b0;
            res_fell_reg    <= 1'b0;
            res_base_reg    <= complete_w ? quo_reg[SAMPLE_W-1:0] : base_int_w;
            res_done_reg    <= complete_w;
        end
        else if (cmd.scan_write)
        begin
            res_pressed_reg <= on_reg;
            res_rose_reg    <= on_reg && !was_reg;
            res_fell_reg    <= !on_reg && was_reg;
            res_base_reg    <= on_reg ? base_int_w : bq_new_w[BASE_W-1:FRAC_W];
            res_done_reg    <= 1'b0;
        end
        else if (cmd.null_write)
        begin
            res_pressed_reg <= 1'b0;
            res_rose_reg    <= 1'b0;
            res_fell_reg    <= 1'b0;
            res_base_reg    <= '0;
            res_done_reg    <= 1'b0;
        end
    end

    assign pad_out     = res_pad_reg;
    assign pressed     = res_pressed_reg;
    assign rose        = res_rose_reg;
    assign fell        = res_fell_reg;
    assign clamped_us  = res_clamped_reg;
    assign baseline_us = res_base_reg;
    assign calib_done  = res_done_reg;

endmodule

[rtl/tpbh_ctrl.sv]
// ----------------------------------------------------------------------------
// tpbh_ctrl
// Sequencer for the touch pad baseline tracker: steps one item through the
// datapath and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module tpbh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  tpbh_pkg::tpbh_stat_t stat,
    output tpbh_pkg::tpbh_cmd_t  cmd
);
    import tpbh_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_FETCH   = 4'd1;
    localparam logic [3:0] S_CAL_ACC = 4'd2;
    localparam logic [3:0] S_CAL_CHK = 4'd3;
    localparam logic [3:0] S_DIV     = 4'd4;
    localparam logic [3:0] S_CAL_WR  = 4'd5;
    localparam logic [3:0] S_MUL_ON  = 4'd6;
    localparam logic [3:0] S_MUL_OFF = 4'd7;
    localparam logic [3:0] S_DECIDE  = 4'd8;
    localparam logic [3:0] S_MUL_TRK = 4'd9;
    localparam logic [3:0] S_SCAN_WR = 4'd10;
    localparam logic [3:0] S_NULL_WR = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    logic       res_load;

    // The result register may take a new item once the old one is gone
    assign out_free = !out_valid_reg || !out_stall;
    assign res_load = cmd.cal_write || cmd.scan_write || cmd.null_write;

    // Advance through the steps of one item
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (!stat.pad_ok)
                begin
                    state_next = S_NULL_WR;
                end
                else if (stat.scan)
                begin
                    state_next = S_MUL_ON;
                end
                else
                begin
                    state_next = S_CAL_ACC;
                end
            end
            S_CAL_ACC:
            begin
                cmd.cal_acc = 1'b1;
                state_next  = S_CAL_CHK;
            end
            S_CAL_CHK:
            begin
                if (stat.cal_complete)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else
                begin
                    state_next = S_CAL_WR;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_CAL_WR;
                end
            end
            S_CAL_WR:
            begin
                if (out_free)
                begin
                    cmd.cal_write = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_MUL_ON:
            begin
                cmd.mul_on = 1'b1;
                state_next = S_MUL_OFF;
            end
            S_MUL_OFF:
            begin
                cmd.mul_off = 1'b1;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_MUL_TRK;
            end
            S_MUL_TRK:
            begin
                cmd.mul_trk = 1'b1;
                state_next  = S_SCAN_WR;
            end
            S_SCAN_WR:
            begin
                if (out_free)
                begin
                    cmd.scan_write = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_NULL_WR:
            begin
                if (out_free)
                begin
                    cmd.null_write = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/tpbh_checker.sv]
// ----------------------------------------------------------------------------
// tpbh_checker
// Port-level checks for the touch pad baseline tracker, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpbh_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic pressed,
    input logic rose,
    input logic fell,
    input logic calib_done
);

    // A result held back downstream stays offered
    `TPBH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    // One item at a time: the input stalls right after an acceptance
    `TPBH_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && !in_stall, in_stall)

    // A press edge leaves the pad pressed and is never a release
    `TPBH_ASSERT_SAME(a_rose_pressed, clk, rst_n, out_valid && rose, pressed && !fell)

    // A release edge leaves the pad released
    `TPBH_ASSERT_SAME(a_fell_released, clk, rst_n, out_valid && fell, !pressed)

    // Finished calibration releases the pad without an edge
    `TPBH_ASSERT_SAME(a_calib_clear, clk, rst_n, out_valid && calib_done,
                      !pressed && !rose && !fell)

endmodule

bind touch_pad_baseline_hysteresis tpbh_checker u_tpbh_checker (.*);

[dv/touch_pad_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_pad_tb_pkg
// Sample modes, spare register indexes and the per-item result record shared
// by the touch pad baseline tracker testbench and its checker.
// ----------------------------------------------------------------------------
package touch_pad_tb_pkg;

    // Kind of charge-time sample carried by an item
    typedef enum logic {
        MODE_CALIB = 1'b0,
        MODE_SCAN  = 1'b1
    } sample_mode_e;

    // Register indexes that decode to nothing
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

    // One result item as it should leave the block
    typedef struct packed {
        logic [3:0]  pad;
        logic        pressed;
        logic        rose;
        logic        fell;
        logic [15:0] clamped;
        logic [15:0] baseline;
        logic        done;
    } pad_result_t;

endpackage

[dv/touch_pad_baseline_hysteresis_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_pad_baseline_hysteresis_checker
// Watches the sample, result and register channels of the baseline tracker,
// keeps its own copy of pad state and registers, predicts each result item
// and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module touch_pad_baseline_hysteresis_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            mode,
    input  logic [tpbh_pkg::PAD_W-1:0]      pad,
    input  logic [tpbh_pkg::SAMPLE_W-1:0]   sample_us,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [tpbh_pkg::PAD_W-1:0]      pad_out,
    input  logic                            pressed,
    input  logic                            rose,
    input  logic                            fell,
    input  logic [tpbh_pkg::SAMPLE_W-1:0]   clamped_us,
    input  logic [tpbh_pkg::SAMPLE_W-1:0]   baseline_us,
    input  logic                            calib_done,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tpbh_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tpbh_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              mismatches,
    output int                              outstanding,
    output int                              results_checked,
    output int                              calibrations,
    output int                              presses
);
    import tpbh_pkg::*;
    import touch_pad_tb_pkg::*;

    // Register copies
    logic [SAMPLE_W-1:0] charge_limit;
    logic [SAMPLE_W-1:0] on_level;
    logic [SAMPLE_W-1:0] off_level;
    logic [GAIN_W-1:0]   gain;
    logic [SEEN_W-1:0]   calib_target;

    // Per-pad state
    logic [PADS_DEFAULT-1:0] press_map;
    logic [BASE_W-1:0]       base_q   [PADS_DEFAULT];
    logic [SUM_W-1:0]        cal_acc  [PADS_DEFAULT];
    logic [SEEN_W-1:0]       cal_cnt  [PADS_DEFAULT];

    // Results still owed by the block, oldest first
    pad_result_t pending_results[$];
    pad_result_t predicted;
    pad_result_t oldest;

    // Update one register copy; unknown indexes fall through
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_MAX_CHARGE: charge_limit = val;
            REG_ON_THR:     on_level     = val;
            REG_OFF_THR:    off_level    = val;
            REG_TRACK_GAIN: gain         = val;
            REG_CALIB_CNT:  calib_target = val[SEEN_W-1:0];
            default: ;
        endcase
    endtask

    // Percentage threshold taken straight from the Q16.16 baseline
    function automatic logic [SAMPLE_W-1:0] pct_threshold(input logic [BASE_W-1:0] bq,
                                                          input logic [GAIN_W-1:0] k);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(bq) * PROD_W'(k);
        return prod[PROD_W-1:BASE_W];
    endfunction

    // Advance the pad model by one sample and form the result it causes
    task automatic track_sample(input logic scan, input logic [PAD_W-1:0] p,
                                input logic [SAMPLE_W-1:0] s, output pad_result_t r);
        logic [SAMPLE_W-1:0] clamped, base_int, delta, thr_on, thr_off;
        logic [SEEN_W-1:0]   need;
        logic [SUM_W-1:0]    mean;
        logic [BASE_W-1:0]   bq, target, diff;
        logic [PROD_W-1:0]   prod;
        logic                was, on;
        clamped = (s < charge_limit) ? s : charge_limit;
        r = '0;
        r.pad = p;
        r.clamped = clamped;
        if (p < PADS_DEFAULT) begin
            was = press_map[p];
            if (!scan) begin
                // accumulate, then average once enough samples are in
                need = (calib_target == '0) ? SEEN_W'(1) : calib_target;
                cal_acc[p] = cal_acc[p] + SUM_W'(clamped);
                if (cal_cnt[p] < SEEN_MAX)
                    cal_cnt[p] = cal_cnt[p] + SEEN_W'(1);
                r.pressed = was;
                if (cal_cnt[p] >= need) begin
                    mean = cal_acc[p] / SUM_W'(cal_cnt[p]);
                    base_q[p] = {mean[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
                    press_map[p] = 1'b0;
                    cal_acc[p] = '0;
                    cal_cnt[p] = '0;
                    r.pressed = 1'b0;
                    r.done = 1'b1;
                end
            end else begin
                // hysteresis decision on the delta above baseline
                bq = base_q[p];
                base_int = bq[BASE_W-1:FRAC_W];
                delta = (clamped > base_int) ? clamped - base_int : '0;
                thr_on = (on_level != '0) ? on_level : pct_threshold(bq, K_ON);
                thr_off = (off_level != '0) ? off_level : pct_threshold(bq, K_OFF);
                if (was)
                    on = (delta >= thr_off);
                else
                    on = (delta >= thr_on) && (clamped < charge_limit);
                if (on) begin
                    press_map[p] = 1'b1;
                end else begin
                    // released pad: let the baseline follow the sample
                    press_map[p] = 1'b0;
                    target = {clamped, {FRAC_W{1'b0}}};
                    if (target >= bq) begin
                        diff = target - bq;
                        prod = PROD_W'(diff) * PROD_W'(gain);
                        bq = bq + prod[PROD_W-1:GAIN_W];
                    end else begin
                        diff = bq - target;
                        prod = PROD_W'(diff) * PROD_W'(gain);
                        bq = bq - prod[PROD_W-1:GAIN_W];
                    end
                    base_q[p] = bq;
                end
                r.pressed = on;
                r.rose = on & ~was;
                r.fell = ~on & was;
            end
            r.baseline = base_q[p][BASE_W-1:FRAC_W];
        end
    endtask

    // Flag one field that differs
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Follow all three channels
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            charge_limit = MAX_CHARGE_RST;
            on_level = ON_THR_RST;
            off_level = OFF_THR_RST;
            gain = GAIN_RST;
            calib_target = CALIB_CNT_RST;
            press_map = '0;
            for (int i = 0; i < PADS_DEFAULT; i++) begin
                base_q[i] = '0;
                cal_acc[i] = '0;
                cal_cnt[i] = '0;
            end
            pending_results.delete();
            mismatches = 0;
            results_checked = 0;
            calibrations = 0;
            presses = 0;
            outstanding <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                write_register(cfg_index, cfg_data);

            // predict each accepted sample item
            if (in_valid && !in_stall) begin
                track_sample(mode == MODE_SCAN, pad, sample_us, predicted);
                if (predicted.done)
                    calibrations++;
                if (predicted.rose)
                    presses++;
                pending_results.push_back(predicted);
            end

            // compare each accepted result item with the oldest prediction
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result item for pad %0d arrived with nothing outstanding",
                           pad_out);
                    mismatches++;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("pad_out", oldest.pad, pad_out);
                    check_field("pressed", oldest.pressed, pressed);
                    check_field("rose", oldest.rose, rose);
                    check_field("fell", oldest.fell, fell);
                    check_field("clamped_us", oldest.clamped, clamped_us);
                    check_field("baseline_us", oldest.baseline, baseline_us);
                    check_field("calib_done", oldest.done, calib_done);
                    results_checked++;
                end
            end

            outstanding <= pending_results.size();
        end
    end

endmodule

[dv/touch_pad_baseline_hysteresis_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_pad_baseline_hysteresis_test
// Drives calibration and scan items into the baseline tracker under a series
// of register settings, with random gaps and output stalls; a side checker
// predicts and compares every result and this top gives the verdict.
// ----------------------------------------------------------------------------
module touch_pad_baseline_hysteresis_test;
    import tpbh_pkg::*;
    import touch_pad_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 500;
    localparam int RANDOM_PHASES  = 10;
    localparam int CALM_PHASE     = 3;
    localparam int SETTLE_CYCLES  = 40;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic                  mode      = 1'b0;
    logic [PAD_W-1:0]      pad       = '0;
    logic [SAMPLE_W-1:0]   sample_us = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PAD_W-1:0]      pad_out;
    logic                  pressed;
    logic                  rose;
    logic                  fell;
    logic [SAMPLE_W-1:0]   clamped_us;
    logic [SAMPLE_W-1:0]   baseline_us;
    logic                  calib_done;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches, outstanding, results_checked, calibrations, presses;
    int items_sent = 0;
    int settings_used = 0;
    int quiet_cycles = 0;
    int level [PADS_DEFAULT];
    bit calm = 1'b0;
    logic [SEEN_W-1:0] cur_calib = CALIB_CNT_RST;

    touch_pad_baseline_hysteresis dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .pad(pad), .sample_us(sample_us),
        .out_valid(out_valid), .out_stall(out_stall),
        .pad_out(pad_out), .pressed(pressed), .rose(rose), .fell(fell),
        .clamped_us(clamped_us), .baseline_us(baseline_us), .calib_done(calib_done),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    touch_pad_baseline_hysteresis_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .pad(pad), .sample_us(sample_us),
        .out_valid(out_valid), .out_stall(out_stall),
        .pad_out(pad_out), .pressed(pressed), .rose(rose), .fell(fell),
        .clamped_us(clamped_us), .baseline_us(baseline_us), .calib_done(calib_done),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .mismatches(mismatches), .outstanding(outstanding),
        .results_checked(results_checked), .calibrations(calibrations),
        .presses(presses)
    );

    // 100 MHz clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stall the result side at random, except in the calm phase
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 14);

    // Abort when no channel has moved for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, outstanding);
            $display("** touch_pad_baseline_hysteresis: FAILED **");
            $finish;
        end
    end

    // Present one sample item, after an optional random gap, and hold it until taken
    task automatic send_item(input sample_mode_e m, input logic [PAD_W-1:0] p,
                             input logic [SAMPLE_W-1:0] s);
        while (!calm && $urandom_range(0, 99) < 14) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= m;
        pad <= p;
        sample_us <= s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
    endtask

    // Hold one register write until taken; the caller drops valid
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Load a full register setting plus one write to an unused index
    task automatic program_regs(input logic [15:0] lim, input logic [15:0] on_t,
                                input logic [15:0] off_t, input logic [15:0] trk,
                                input logic [15:0] cal);
        write_reg(REG_MAX_CHARGE, lim);
        write_reg(REG_ON_THR, on_t);
        write_reg(REG_OFF_THR, off_t);
        write_reg(REG_TRACK_GAIN, trk);
        write_reg(REG_CALIB_CNT, cal);
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                  CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
        cur_calib = cal[SEEN_W-1:0];
        settings_used++;
    endtask

    // Drop valid and wait until every result has come back
    task automatic wait_idle;
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Typical pad charge level, now and then anywhere in range
    function automatic int pick_level();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 65535);
        return $urandom_range(100, 3000);
    endfunction

    // Sample spread around a level: down by lvl/below, up by lvl/above plus two
    function automatic logic [SAMPLE_W-1:0] near_level(input int lvl, input int below,
                                                       input int above);
        int lo, hi, v;
        lo = lvl - lvl / below;
        hi = lvl + lvl / above + 2;
        v = $urandom_range(hi, lo);
        if (v > 65535)
            v = 65535;
        return SAMPLE_W'(v);
    endfunction

    initial begin
        int ph, phase_end, n, pick;
        logic [PAD_W-1:0] p;
        logic [15:0] lim, on_t, off_t, trk, cal;

        foreach (level[i])
            level[i] = -1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: calibrate, press with hysteresis, release, limit blocks press
        wait_idle;
        program_regs(16'd2000, 16'd0, 16'd0, 16'd655, 16'd2);
        send_item(MODE_CALIB, 4'd0, 16'd1000);
        send_item(MODE_CALIB, 4'd0, 16'd1010);
        send_item(MODE_SCAN, 4'd0, 16'd1000);
        send_item(MODE_SCAN, 4'd0, 16'd1200);
        send_item(MODE_SCAN, 4'd0, 16'd1100);
        send_item(MODE_SCAN, 4'd0, 16'd1050);
        send_item(MODE_SCAN, 4'd0, 16'hFFFF);
        send_item(MODE_SCAN, 4'd0, 16'd0);
        // zero baseline presses on anything below the limit; calibration clears it
        send_item(MODE_SCAN, 4'd15, 16'd0);
        send_item(MODE_SCAN, 4'd15, 16'd1);
        send_item(MODE_CALIB, 4'd15, 16'hFFFF);
        send_item(MODE_CALIB, 4'd15, 16'd0);
        send_item(MODE_SCAN, 4'd9, 16'd1999);

        // Directed: full-scale registers, calibration count of zero
        wait_idle;
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0100);
        send_item(MODE_CALIB, 4'd3, 16'hFFFF);
        send_item(MODE_SCAN, 4'd3, 16'hFFFF);
        send_item(MODE_SCAN, 4'd9, 16'd0);
        send_item(MODE_CALIB, 4'd5, 16'd0);
        send_item(MODE_SCAN, 4'd5, 16'hFFFF);

        // Directed: minimum limit and thresholds, zero gain, longest calibration
        wait_idle;
        program_regs(16'd1, 16'd1, 16'd1, 16'd0, 16'd255);
        send_item(MODE_SCAN, 4'd6, 16'hFFFF);
        send_item(MODE_SCAN, 4'd6, 16'd0);
        send_item(MODE_CALIB, 4'd7, 16'd40000);
        send_item(MODE_CALIB, 4'd7, 16'd0);

        // Directed: lower the count below the samples already summed
        wait_idle;
        program_regs(16'd2000, 16'd0, 16'd0, 16'd655, 16'd1);
        send_item(MODE_CALIB, 4'd7, 16'd500);
        send_item(MODE_SCAN, 4'd7, 16'd300);

        // Random phases, one register setting each
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle;
            calm = (ph == CALM_PHASE);
            case ($urandom_range(0, 4))
                0: lim = 16'd2000;
                1: lim = 16'($urandom_range(500, 4000));
                2: lim = 16'hFFFF;
                3: lim = 16'($urandom_range(1, 65535));
                default: lim = 16'($urandom_range(1, 60));
            endcase
            case ($urandom_range(0, 3))
                0, 1: on_t = 16'd0;
                2: on_t = 16'($urandom_range(1, 400));
                default: on_t = 16'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0, 1: off_t = 16'd0;
                2: off_t = 16'($urandom_range(1, 200));
                default: off_t = 16'($urandom);
            endcase
            case ($urandom_range(0, 4))
                0: trk = 16'd655;
                1: trk = 16'd0;
                2: trk = 16'hFFFF;
                3: trk = 16'($urandom);
                default: trk = 16'd8192;
            endcase
            case ($urandom_range(0, 4))
                0, 1: cal = 16'($urandom_range(1, 4));
                2: cal = 16'($urandom_range(5, 20));
                3: cal = {8'($urandom), 8'h00};
                default: cal = 16'd255;
            endcase
            program_regs(lim, on_t, off_t, trk, cal);

            phase_end = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (items_sent < phase_end) begin
                p = PAD_W'($urandom_range(0, PADS_DEFAULT - 1));
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    // calibration burst around a level, sometimes cut short
                    if (level[p] < 0 || $urandom_range(0, 2) == 0)
                        level[p] = pick_level();
                    n = (cur_calib == '0) ? 1 : int'(cur_calib);
                    if (n > 20)
                        n = $urandom_range(1, 4);
                    else if ($urandom_range(0, 5) == 0)
                        n = $urandom_range(1, n);
                    repeat (n)
                        send_item(MODE_CALIB, p, near_level(level[p], 16, 16));
                end else if (pick < 75) begin
                    // scan burst around the level, crossing both thresholds
                    if (level[p] < 0)
                        level[p] = pick_level();
                    repeat ($urandom_range(1, 10))
                        send_item(MODE_SCAN, p, near_level(level[p], 6, 3));
                end else begin
                    send_item(sample_mode_e'($urandom_range(0, 1)), p, 16'($urandom));
                end
            end
        end

        // Drain and settle
        wait_idle;
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d items under %0d register settings; %0d results checked,",
                 items_sent, settings_used, results_checked);
        $display("%0d calibrations completed and %0d pad presses seen.",
                 calibrations, presses);
        if (mismatches == 0 && outstanding == 0)
            $display("** touch_pad_baseline_hysteresis: PASSED **");
        else
            $display("** touch_pad_baseline_hysteresis: FAILED **");
        $finish;
    end

endmodule
